>>> hdl/cms_pkg.sv
// Shared types and constants for the count-min sketch unit.
package cms_pkg;

    localparam int KEY_W      = 31;
    localparam int INC_W      = 32;
    localparam int CNT_W      = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;

    // Hash coefficient storage always holds four rows
    localparam int HASH_ROWS_MAX  = 4;
    localparam int HASH_ROW_IDX_W = 2;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Low bit of the register index picks multiplier or offset
    localparam logic CFG_SEL_MULT = 1'b0;
    localparam logic CFG_SEL_ADD  = 1'b1;

    // Prime just above 2^32; 2^32 == -HASH_FOLD (mod HASH_PRIME)
    localparam logic [32:0] HASH_PRIME = 33'h1_0000_000F;
    localparam logic [7:0]  HASH_FOLD  = 8'(HASH_PRIME - 33'h1_0000_0000);

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic issue_row;
        logic load_result;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic issue_last;
        logic rows_done;
    } ctl_stat_t;

endpackage

>>> hdl/cms_if.sv
// Request and result channel interfaces of the count-min sketch unit.
interface cms_req_if
    import cms_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [KEY_W-1:0]  item_key;
    logic signed [INC_W-1:0] increment;

    modport source (output valid, output cmd, output item_key, output increment,
                    input ready);
    modport sink (input valid, input cmd, input item_key, input increment,
                  output ready);
endinterface

interface cms_rsp_if
    import cms_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CNT_W-1:0]  estimate;
    logic [CNT_W-1:0]  total_out;

    modport source (output valid, output estimate, output total_out, input ready);
    modport sink (input valid, input estimate, input total_out, output ready);
endinterface

>>> hdl/cms_hash.sv
// Eight-stage bucket hash pipeline: ((mult*key + add) mod prime) mod buckets.
module cms_hash
    import cms_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int ROW_W   = 2,
    parameter int BW      = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [ROW_W-1:0]  in_row,
    input  logic              in_last,
    input  logic [KEY_W-1:0]  mult,
    input  logic [KEY_W-1:0]  add,
    input  logic [KEY_W-1:0]  key,
    output logic              out_valid,
    output logic [ROW_W-1:0]  out_row,
    output logic              out_last,
    output logic [BW-1:0]     bucket
);

    localparam int STAGES = 8;
    localparam logic [63:0] TWO_POW32 = 64'h1_0000_0000;
    // floor(2^32 / B): quotient estimate is exact or one low
    localparam logic [31:0] RECIP    = 32'(TWO_POW32 / BUCKETS);
    localparam logic [17:0] BKT      = 18'(BUCKETS);
    localparam logic [17:0] WRAP_REM = 18'(TWO_POW32 % BUCKETS);

    logic [61:0] p1_reg;
    logic [30:0] a1_reg;
    logic [62:0] h2_reg;
    logic [36:0] t3_reg;
    logic [32:0] x4_reg;
    logic [63:0] m5_reg;
    logic [32:0] x5_reg;
    logic [32:0] qb6_reg;
    logic [32:0] x6_reg;
    logic [16:0] r7_reg;
    logic        hi7_reg;
    logic [BW-1:0] bkt8_reg;

    logic [STAGES-1:0] vld_reg;
    logic [ROW_W-1:0]  row_reg [STAGES];
    logic              last_reg [STAGES];

    logic [61:0] p1_next;
    logic [62:0] h2_next;
    logic [38:0] hi_fold;
    logic [36:0] t3_next;
    logic [3:0]  neg_hi;
    logic [11:0] lo_fold;
    logic [32:0] fold_sum;
    logic [32:0] x4_next;
    logic [63:0] m5_next;
    logic [48:0] qb_full;
    logic [32:0] diff;
    logic [17:0] rem_est;
    logic [16:0] r7_next;
    logic [17:0] rem_sum;
    logic [17:0] rem_fix;

    always_comb
    begin
        p1_next = {31'b0, mult} * {31'b0, key};
        h2_next = {1'b0, p1_reg} + {32'b0, a1_reg};

        // h = hi*2^32 + lo == lo - FOLD*hi; result lies in (-8*2^32, 2^32)
        hi_fold = {8'b0, h2_reg[62:32]} * {31'b0, HASH_FOLD};
        t3_next = {5'b0, h2_reg[31:0]} - hi_fold[36:0];

        // second fold of the small negative upper part, then one correction
        neg_hi   = 4'(5'd0 - t3_reg[36:32]);
        lo_fold  = {8'b0, neg_hi} * {4'b0, HASH_FOLD};
        fold_sum = {1'b0, t3_reg[31:0]} + {21'b0, lo_fold};
        x4_next  = (fold_sum >= HASH_PRIME) ? fold_sum - HASH_PRIME : fold_sum;

        m5_next = {32'b0, x4_reg[31:0]} * {32'b0, RECIP};
        qb_full = {17'b0, m5_reg[63:32]} * {31'b0, BKT};

        diff    = {1'b0, x6_reg[31:0]} - qb6_reg;
        rem_est = diff[17:0];
        r7_next = (rem_est >= BKT) ? 17'(rem_est - BKT) : rem_est[16:0];

        // bit 32 of the prime residue contributes 2^32 mod B
        rem_sum = {1'b0, r7_reg} + (hi7_reg ? WRAP_REM : 18'd0);
        rem_fix = (rem_sum >= BKT) ? rem_sum - BKT : rem_sum;
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= p1_next;
        a1_reg   <= add;
        h2_reg   <= h2_next;
        t3_reg   <= t3_next;
        x4_reg   <= x4_next;
        m5_reg   <= m5_next;
        x5_reg   <= x4_reg;
        qb6_reg  <= qb_full[32:0];
        x6_reg   <= x5_reg;
        r7_reg   <= r7_next;
        hi7_reg  <= x6_reg[32];
        bkt8_reg <= BW'(rem_fix);
        row_reg[0]  <= in_row;
        last_reg[0] <= in_last;
        for (int i = 1; i < STAGES; i++)
        begin
            row_reg[i]  <= row_reg[i-1];
            last_reg[i] <= last_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_row   = row_reg[STAGES-1];
    assign out_last  = last_reg[STAGES-1];
    assign bucket    = bkt8_reg;

endmodule

>>> hdl/cms_dp.sv
// Datapath: coefficient registers, item registers, counter memory and result registers.
module cms_dp
    import cms_pkg::*;
#(
    parameter int ROWS    = 4,
    parameter int BUCKETS = 1024,
    parameter int ROW_W   = 2,
    parameter int BW      = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctl_cmd_t                ctl,
    output ctl_stat_t               stat,
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    cmd,
    input  logic [KEY_W-1:0]        item_key,
    input  logic signed [INC_W-1:0] increment,
    output logic [CNT_W-1:0]        estimate,
    output logic [CNT_W-1:0]        total_out
);

    localparam int ADDR_W    = ROW_W + BW;
    localparam int MEM_DEPTH = ROWS * (2 ** BW);

    logic [KEY_W-1:0] mult_reg [HASH_ROWS_MAX];
    logic [KEY_W-1:0] add_reg  [HASH_ROWS_MAX];

    logic             cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [INC_W-1:0] inc_reg;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] min_reg;
    logic [CNT_W-1:0] est_out_reg;
    logic [CNT_W-1:0] total_out_reg;
    logic [ROW_W-1:0] row_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    logic [CNT_W-1:0]  mem [MEM_DEPTH];
    logic [CNT_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rmw_addr_reg;
    logic              rmw_vld_reg;
    logic              rmw_last_reg;

    logic [HASH_ROW_IDX_W-1:0] cfg_row;
    logic [HASH_ROW_IDX_W-1:0] hash_row;
    logic              h_valid;
    logic [ROW_W-1:0]  h_row;
    logic              h_last;
    logic [BW-1:0]     h_bucket;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    assign cfg_row  = cfg_addr[CFG_ADDR_W-1:1];
    assign hash_row = HASH_ROW_IDX_W'(row_cnt_reg);
    assign rd_addr  = {h_row, h_bucket};
    assign wr_en    = rmw_vld_reg && (cmd_reg == CMD_UPDATE);

    assign stat.clear_last = (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1));
    assign stat.issue_last = (row_cnt_reg == ROW_W'(ROWS - 1));
    assign stat.rows_done  = rmw_vld_reg && rmw_last_reg;

    cms_hash #(
        .BUCKETS (BUCKETS),
        .ROW_W   (ROW_W),
        .BW      (BW)
    ) u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ctl.issue_row),
        .in_row    (row_cnt_reg),
        .in_last   (stat.issue_last),
        .mult      (mult_reg[hash_row]),
        .add       (add_reg[hash_row]),
        .key       (key_reg),
        .out_valid (h_valid),
        .out_row   (h_row),
        .out_last  (h_last),
        .bucket    (h_bucket)
    );

    // hash coefficients, total and sequencing counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HASH_ROWS_MAX; i++)
            begin
                mult_reg[i] <= '0;
                add_reg[i]  <= '0;
            end
            total_reg    <= '0;
            row_cnt_reg  <= '0;
            clr_cnt_reg  <= '0;
            rmw_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr[0] == CFG_SEL_ADD)
                begin
                    add_reg[cfg_row] <= cfg_data;
                end
                else
                begin
                    mult_reg[cfg_row] <= cfg_data;
                end
            end
            if (ctl.load_item && (cmd == CMD_UPDATE))
            begin
                total_reg <= total_reg + increment;
            end
            if (ctl.load_item)
            begin
                row_cnt_reg <= '0;
            end
            else if (ctl.issue_row && !stat.issue_last)
            begin
                row_cnt_reg <= row_cnt_reg + 1'b1;
            end
            if (ctl.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            rmw_vld_reg <= h_valid;
        end
    end

    // item, running minimum and result registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            cmd_reg <= cmd;
            key_reg <= item_key;
            inc_reg <= increment;
            min_reg <= '1;
        end
        else if (rmw_vld_reg && (rd_data_reg < min_reg))
        begin
            min_reg <= rd_data_reg;
        end
        rmw_addr_reg <= rd_addr;
        rmw_last_reg <= h_last;
        if (ctl.load_result)
        begin
            est_out_reg   <= (cmd_reg == CMD_QUERY) ? min_reg : '0;
            total_out_reg <= total_reg;
        end
    end

    // counter memory: clear sweep, registered read, write-back in the cycle after the read
    always_ff @(posedge clk)
    begin
        if (ctl.clear_step)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[rmw_addr_reg] <= rd_data_reg + inc_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign estimate  = est_out_reg;
    assign total_out = total_out_reg;

endmodule

>>> hdl/cms_ctrl.sv
// Controller: sequences clearing, row issue, memory drain and result hand-off.
module cms_ctrl
    import cms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ctl_stat_t stat,
    output ctl_cmd_t  ctl
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ISSUE = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        ctl            = '0;
        state_next     = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                ctl.issue_row = 1'b1;
                if (stat.issue_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (stat.rows_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ctl.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ctl.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/count_min_sketch_unit.sv
// Top level of the count-min sketch unit: controller plus datapath.
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+----------------------------------------
//  req     | in  | valid / ready  | cmd, item_key[30:0], increment[31:0]
//  rsp     | out | valid / ready  | estimate[31:0], total_out[31:0]
//  cfg     | in  | cfg_we only    | cfg_addr[2:0], cfg_data[30:0]
//
// One request at a time. Once a request is accepted, its ROWS rows are issued
// into the eight-stage hash pipeline; the last row then passes seven more hash
// stages, its registered memory read, its write-back, and the load of the output
// register before the result is ready. The next request can be taken in the same
// cycle that the result appears.
// After reset the memory is cleared one entry per cycle, ROWS * 2^clog2(BUCKETS)
// entries (4096 at the defaults); req.ready stays low until that sweep ends.
// The result waits in an output register, so the next request is taken
// while rsp is stalled; it only blocks at hand-off if the old result is
// still unread.
module count_min_sketch_unit
    import cms_pkg::*;
#(
    parameter int ROWS    = 4,
    parameter int BUCKETS = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    cms_req_if.sink               req,
    cms_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // row tag width; at least one bit so a single-row build still elaborates
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    // bucket index width
    localparam int BW    = $clog2(BUCKETS);

    ctl_cmd_t  ctl;
    ctl_stat_t stat;

    cms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    cms_dp #(
        .ROWS    (ROWS),
        .BUCKETS (BUCKETS),
        .ROW_W   (ROW_W),
        .BW      (BW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cmd       (req.cmd),
        .item_key  (req.item_key),
        .increment (req.increment),
        .estimate  (rsp.estimate),
        .total_out (rsp.total_out)
    );

endmodule

>>> bench/count_min_sketch_unit_tb.sv
// Self-checking bench for the count-min sketch unit: directed and random requests against a sketch model.
module count_min_sketch_unit_tb;
    import cms_pkg::*;

    // DUT build; the model below is sized to match
    localparam int SKETCH_ROWS    = 4;
    localparam int SKETCH_BUCKETS = 1024;

    // Settling margin before reconfig and at the end
    localparam int SETTLE_CYCLES = 40;
    // Clearing sweep + ~520 requests with worst gaps and stalls, several times over
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int KEY_POOL_N    = 12;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    // Register indexes of the config port, row-major, multiplier then offset
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROW0_MULT, REG_ROW0_ADD, REG_ROW1_MULT, REG_ROW1_ADD,
        REG_ROW2_MULT, REG_ROW2_ADD, REG_ROW3_MULT, REG_ROW3_ADD
    } hash_reg_e;

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] item_key;
        logic [INC_W-1:0] increment;
    } sketch_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] estimate;
        logic [CNT_W-1:0] total_out;
    } sketch_rsp_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    cms_req_if req_ch ();
    cms_rsp_if rsp_ch ();

    count_min_sketch_unit #(
        .ROWS    (SKETCH_ROWS),
        .BUCKETS (SKETCH_BUCKETS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // ---------------------------------------------------------------
    // Sketch model: counters, running total and hash coefficients.
    // Cleared at declaration, which matches the state after reset.
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]      tally [SKETCH_ROWS][SKETCH_BUCKETS] = '{default: '0};
    logic [CNT_W-1:0]      grand_total = '0;
    logic [CFG_DATA_W-1:0] hash_mult [HASH_ROWS_MAX] = '{default: '0};
    logic [CFG_DATA_W-1:0] hash_add  [HASH_ROWS_MAX] = '{default: '0};

    sketch_req_t      req_queue [$];   // requests waiting for the driver
    sketch_rsp_t      answer_q  [$];   // predicted results, oldest first
    logic [KEY_W-1:0] key_pool [KEY_POOL_N];

    bit req_took;          // request handshake seen at the last rising edge
    bit idling_on;         // random gaps on both channels when set
    int send_gap_left;
    int rsp_gap_left;
    int rsp_hold_left;     // long receiver hold-off, counted down by the receiver
    int err_cnt;
    int results_seen;
    int cycle_cnt;

    // Exact hash: product is below 2^62, so 64 bits hold it with the offset
    function automatic int unsigned bucket_of_key(int row, logic [KEY_W-1:0] key);
        logic [63:0] h;
        h = 64'(hash_mult[row]) * 64'(key) + 64'(hash_add[row]);
        return int'((h % 64'(HASH_PRIME)) % 64'(SKETCH_BUCKETS));
    endfunction

    // Applies one request to the model and returns the result it should give
    function automatic sketch_rsp_t apply_to_sketch(sketch_req_t rq);
        sketch_rsp_t ans;
        int unsigned b;
        ans.estimate = '0;
        if (rq.cmd == CMD_UPDATE)
        begin
            grand_total = grand_total + rq.increment;
            for (int r = 0; r < SKETCH_ROWS; r++)
            begin
                b = bucket_of_key(r, rq.item_key);
                tally[r][b] = tally[r][b] + rq.increment;
            end
        end
        else
        begin
            // unsigned minimum over the rows; increment plays no part
            ans.estimate = '1;
            for (int r = 0; r < SKETCH_ROWS; r++)
            begin
                b = bucket_of_key(r, rq.item_key);
                if (tally[r][b] < ans.estimate)
                    ans.estimate = tally[r][b];
            end
        end
        ans.total_out = grand_total;
        return ans;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int idle_length();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 40);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_coef();
        return ($urandom_range(0, 7) == 0) ? '0 : CFG_DATA_W'($urandom);
    endfunction

    function automatic sketch_req_t random_request();
        sketch_req_t rq;
        rq.cmd = ($urandom_range(0, 99) < 55) ? CMD_UPDATE : CMD_QUERY;
        // reuse a small key set so queries land on counters that were updated
        if ($urandom_range(0, 3) != 0)
            rq.item_key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
        else
            rq.item_key = KEY_W'($urandom);
        case ($urandom_range(0, 9))
            0: rq.increment = $urandom;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: rq.increment = 32'h7FFF_FFFF;
                    1: rq.increment = 32'h8000_0000;
                    2: rq.increment = 32'hFFFF_FFFF;
                    default: rq.increment = '0;
                endcase
            end
            default: rq.increment = INC_W'(int'($urandom_range(0, 200)) - 100);
        endcase
        return rq;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    // ---------------------------------------------------------------
    // Clock and watchdog
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d results checked", cycle_cnt, results_seen);
        $display("count_min_sketch_unit verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Request driver: presents queued requests at the falling edge and
    // holds each one until the block takes it.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        sketch_req_t seen;
        req_took = rst_n && req_ch.valid === 1'b1 && req_ch.ready === 1'b1;
        if (req_took)
        begin
            // predict from what the block actually saw on the bus
            seen.cmd       = req_ch.cmd;
            seen.item_key  = req_ch.item_key;
            seen.increment = req_ch.increment;
            answer_q.push_back(apply_to_sketch(seen));
        end
    end

    always @(negedge clk)
    begin
        sketch_req_t nxt;
        if (!rst_n || (req_ch.valid && !req_took))
        begin
            // in reset, or the current request is still waiting: hold
        end
        else if (send_gap_left > 0)
        begin
            req_ch.valid <= 1'b0;
            send_gap_left--;
        end
        else if (req_queue.size() != 0)
        begin
            nxt = req_queue.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.cmd       <= nxt.cmd;
            req_ch.item_key  <= nxt.item_key;
            req_ch.increment <= nxt.increment;
            if (idling_on && $urandom_range(0, 2) == 0)
                send_gap_left = idle_length();
        end
        else
            req_ch.valid <= 1'b0;
    end

    // ---------------------------------------------------------------
    // Result side: ready pattern, then compare each taken result with
    // the oldest prediction.
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rsp_hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_left--;
        end
        else if (rsp_gap_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_gap_left--;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if (idling_on && $urandom_range(0, 3) == 0)
                rsp_gap_left = idle_length();
        end
    end

    always @(posedge clk)
    begin
        sketch_rsp_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (answer_q.size() == 0)
                report_mismatch($sformatf("result with no request outstanding: est %h total %h",
                                          rsp_ch.estimate, rsp_ch.total_out));
            else
            begin
                want = answer_q.pop_front();
                if (rsp_ch.estimate !== want.estimate)
                    report_mismatch($sformatf("result %0d estimate got %h want %h",
                                              results_seen, rsp_ch.estimate, want.estimate));
                if (rsp_ch.total_out !== want.total_out)
                    report_mismatch($sformatf("result %0d total_out got %h want %h",
                                              results_seen, rsp_ch.total_out, want.total_out));
            end
            results_seen++;
        end
    end

    // ---------------------------------------------------------------
    // Sequencing helpers
    // ---------------------------------------------------------------
    task automatic write_reg(input hash_reg_e idx, input logic [CFG_DATA_W-1:0] val);
        logic [CFG_ADDR_W-1:0] a;
        a = idx;
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= a;
        cfg_data <= val;
        @(posedge clk);
        if (a[0] == CFG_SEL_MULT)
            hash_mult[a[CFG_ADDR_W-1:1]] = val;
        else
            hash_add[a[CFG_ADDR_W-1:1]] = val;
    endtask

    task automatic set_row(input int row, input logic [CFG_DATA_W-1:0] mult,
                           input logic [CFG_DATA_W-1:0] add);
        write_reg(hash_reg_e'({HASH_ROW_IDX_W'(row), CFG_SEL_MULT}), mult);
        write_reg(hash_reg_e'({HASH_ROW_IDX_W'(row), CFG_SEL_ADD}), add);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_item(input logic cmd, input logic [KEY_W-1:0] key,
                             input logic [INC_W-1:0] inc);
        sketch_req_t rq;
        rq.cmd       = cmd;
        rq.item_key  = key;
        rq.increment = inc;
        req_queue.push_back(rq);
    endtask

    // Waits until every request is taken and answered, then for the settling margin
    task automatic wait_idle();
        while (req_queue.size() != 0 || req_ch.valid || answer_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int n_items, input bit with_idling, input int hold_cycles);
        @(posedge clk);
        idling_on = with_idling;
        key_pool[0] = '0;
        key_pool[1] = KEY_MAX;
        for (int i = 2; i < KEY_POOL_N; i++)
            key_pool[i] = KEY_W'($urandom);
        // receiver holds off while the sender keeps offering: block fills and stalls
        rsp_hold_left = hold_cycles;
        repeat (n_items) req_queue.push_back(random_request());
        wait_idle();
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_addr         = '0;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.cmd       = CMD_UPDATE;
        req_ch.item_key  = '0;
        req_ch.increment = '0;
        rsp_ch.ready     = 1'b0;
        idling_on        = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Coefficients still zero: every key hits bucket 0 in every row.
        // Walk the counters through signed overflow and the unsigned wrap.
        @(posedge clk);
        push_item(CMD_QUERY,  '0,               32'h0000_0000);
        push_item(CMD_QUERY,  KEY_MAX,          32'hFFFF_FFFF);
        push_item(CMD_UPDATE, '0,               32'h7FFF_FFFF);
        push_item(CMD_UPDATE, KEY_MAX,          32'h0000_0001);
        push_item(CMD_QUERY,  31'd12345,        32'h0000_0000);
        push_item(CMD_UPDATE, 31'h5555_5555,    32'h8000_0000);
        push_item(CMD_UPDATE, 31'h2AAA_AAAA,    32'hFFFF_FFFF);
        push_item(CMD_QUERY,  31'h0F0F_0F0F,    32'h1234_5678);  // increment ignored
        push_item(CMD_UPDATE, 31'd7,            32'h0000_0001);
        push_item(CMD_QUERY,  31'd7,            32'hFFFF_FFFF);
        wait_idle();

        // Rows spread apart; one bucket of row three driven below zero so the
        // estimate only comes out right with an unsigned minimum
        set_row(0, 31'd1, 31'd0);
        set_row(1, 31'd1, 31'd1);
        set_row(2, KEY_MAX, KEY_MAX);
        set_row(3, 31'd2, 31'd5);
        @(posedge clk);
        push_item(CMD_UPDATE, 31'd0,            32'h0000_000A);
        push_item(CMD_UPDATE, 31'd1,            32'hFFFF_FFFD);
        push_item(CMD_UPDATE, 31'd512,          32'hFFFF_FFF0);
        push_item(CMD_QUERY,  31'd0,            32'h0000_0000);
        push_item(CMD_QUERY,  31'd512,          32'h0000_0000);
        push_item(CMD_QUERY,  31'd1,            32'h0000_0000);
        push_item(CMD_QUERY,  KEY_MAX,          32'h1234_5678);
        wait_idle();

        // Largest coefficients: products far above the prime
        for (int r = 0; r < HASH_ROWS_MAX; r++)
            set_row(r, KEY_MAX, KEY_MAX);
        run_phase(100, 1'b1, 0);

        // Random coefficients, with a long receiver hold-off at the start
        for (int r = 0; r < HASH_ROWS_MAX; r++)
            set_row(r, random_coef(), random_coef());
        run_phase(100, 1'b1, 400);

        // Identity hash on every row, no idling at all
        for (int r = 0; r < HASH_ROWS_MAX; r++)
            set_row(r, 31'd1, '0);
        run_phase(100, 1'b0, 0);

        // Tiny coefficients: lots of shared buckets across keys
        for (int r = 0; r < HASH_ROWS_MAX; r++)
            set_row(r, CFG_DATA_W'($urandom_range(0, 8)), CFG_DATA_W'($urandom_range(0, 8)));
        run_phase(100, 1'b1, 0);

        for (int r = 0; r < HASH_ROWS_MAX; r++)
            set_row(r, random_coef(), random_coef());
        run_phase(100, 1'b1, 0);

        if (err_cnt == 0)
            $display("count_min_sketch_unit verification clean");
        else
            $display("count_min_sketch_unit verification failed");
        $finish;
    end

endmodule
